// File: rtl/sstd_pkg.sv
// ----------------------------------------------------------------------------
// sstd_pkg
// Shared types, constants and decimal split helpers for the four-digit
// seven-segment timer display.
// ----------------------------------------------------------------------------
package sstd_pkg;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_SHOW_NUMBER = 3'd1,
        OP_SHOW_DASHES = 3'd2,
        OP_SET_DOT     = 3'd3,
        OP_CLEAR_COUNT = 3'd4
    } t_op;

    localparam logic [7:0] PRESCALE_RESET = 8'd5;
    localparam logic [6:0] GLYPH_DASH     = 7'h40;
    localparam logic [6:0] GLYPH_BLANK    = 7'h00;
    localparam logic [6:0] GLYPH_ZERO     = 7'h3F;
    localparam logic [1:0] POINT_ROW      = 2'd2;

    localparam int TEN_THOUSAND = 10000;
    localparam int THOUSAND     = 1000;
    localparam int HUNDRED      = 100;
    localparam int TEN          = 10;

    // Upper part of the decimal split, done ahead of the input register.
    typedef struct packed {
        logic [9:0] rem;        // value mod 1000
        logic [3:0] thousands;  // thousands digit of value mod 10000
        logic       big;        // value is 1000 or more
    } t_front;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_low;

    typedef struct packed {
        logic tick;
        logic clear;
    } t_cnt_ctrl;

    typedef struct packed {
        logic [15:0] count;
        logic        advanced;
    } t_cnt_stat;

    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] g;
        begin
            case (d)
                4'd0:    g = 7'h3F;
                4'd1:    g = 7'h06;
                4'd2:    g = 7'h5B;
                4'd3:    g = 7'h4F;
                4'd4:    g = 7'h66;
                4'd5:    g = 7'h6D;
                4'd6:    g = 7'h7D;
                4'd7:    g = 7'h27;
                4'd8:    g = 7'h7F;
                4'd9:    g = 7'h6F;
                default: g = GLYPH_BLANK;
            endcase
            return g;
        end
    endfunction

    // Each level compares against all multiples of its power of ten in
    // parallel and subtracts the largest one that fits.
    function automatic t_front split_front(input logic [15:0] v);
        t_front      f;
        logic [15:0] sub_hi;
        logic [13:0] r;
        logic [13:0] sub_lo;
        logic [3:0]  q;
        begin
            sub_hi = '0;
            for (int k = 1; k <= 6; k++) begin
                if (v >= 16'(k * TEN_THOUSAND)) begin
                    sub_hi = 16'(k * TEN_THOUSAND);
                end
            end
            r      = 14'(v - sub_hi);
            q      = '0;
            sub_lo = '0;
            for (int k = 1; k <= 9; k++) begin
                if (r >= 14'(k * THOUSAND)) begin
                    q      = 4'(k);
                    sub_lo = 14'(k * THOUSAND);
                end
            end
            f.rem       = 10'(r - sub_lo);
            f.thousands = q;
            f.big       = (v >= 16'(THOUSAND));
            return f;
        end
    endfunction

    function automatic t_low split_low(input logic [9:0] r);
        t_low       l;
        logic [9:0] sub_h;
        logic [6:0] r2;
        logic [6:0] sub_t;
        begin
            l.hundreds = '0;
            sub_h      = '0;
            for (int k = 1; k <= 9; k++) begin
                if (r >= 10'(k * HUNDRED)) begin
                    l.hundreds = 4'(k);
                    sub_h      = 10'(k * HUNDRED);
                end
            end
            r2     = 7'(r - sub_h);
            l.tens = '0;
            sub_t  = '0;
            for (int k = 1; k <= 9; k++) begin
                if (r2 >= 7'(k * TEN)) begin
                    l.tens = 4'(k);
                    sub_t  = 7'(k * TEN);
                end
            end
            l.ones = 4'(r2 - sub_t);
            return l;
        end
    endfunction

endpackage

// File: rtl/sstd_prescaler.sv
// ----------------------------------------------------------------------------
// sstd_prescaler
// Tick prescaler and wrapping 16-bit elapsed counter.
// ----------------------------------------------------------------------------
module sstd_prescaler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sstd_pkg::t_cnt_ctrl   i_ctrl,
    input  logic [7:0]            i_prescale,
    output sstd_pkg::t_cnt_stat   o_stat
);

    logic [7:0]  r_left;
    logic [15:0] r_total;
    logic [7:0]  n_left;
    logic [15:0] n_total;
    logic [7:0]  dec_left;
    logic        adv;

    assign dec_left = r_left - 8'd1;

    always_comb begin
        n_left  = r_left;
        n_total = r_total;
        adv     = 1'b0;
        if (i_ctrl.clear) begin
            n_left  = i_prescale;
            n_total = '0;
        end else if (i_ctrl.tick) begin
            // A prescale of zero reloads zero, so the next tick wraps to 255.
            if (dec_left == 8'd0) begin
                n_left  = i_prescale;
                n_total = r_total + 16'd1;
                adv     = 1'b1;
            end else begin
                n_left = dec_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= sstd_pkg::PRESCALE_RESET;
            r_total <= '0;
        end else begin
            r_left  <= n_left;
            r_total <= n_total;
        end
    end

    assign o_stat.count    = n_total;
    assign o_stat.advanced = adv;

endmodule

// File: rtl/seven_segment_timer_display.sv
// ----------------------------------------------------------------------------
// seven_segment_timer_display
// Four-digit multiplexed seven-segment driver with a prescaled elapsed count.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while its input side does not
// stall. A request is captured in an input register and executed in the
// following cycle unless it is held there; an executed tick writes its result
// into the result register. The only thing that holds the input back is the
// result register: while a result is stalled on the output, a tick that
// waits in the input register stays there and the input side stalls. The
// decimal split of a show-number request is done in two levels, thousands
// before the input register and hundreds, tens and ones after it, so the new
// glyphs are in place for a tick that follows right behind. Writes to the
// prescale register take effect at the next reload of the prescaler.
// ----------------------------------------------------------------------------
module seven_segment_timer_display (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_value,
    input  logic        i_dot_on,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_digit_index,
    output logic [7:0]  o_segments,
    output logic [15:0] o_elapsed_count,
    output logic        o_count_advanced
);

    logic [7:0]            r_prescale;

    // input register
    logic                  r_in_vld;
    sstd_pkg::t_op         r_op;
    logic                  r_dot_in;
    sstd_pkg::t_front      r_front;

    // display state
    logic [6:0]            r_glyph [4];
    logic [6:0]            n_glyph [4];
    logic                  r_dot;
    logic                  n_dot;
    logic [1:0]            r_scan;
    logic [1:0]            n_scan;

    // result register
    logic                  r_out_vld;
    logic                  n_out_vld;
    logic [1:0]            r_digit;
    logic [7:0]            r_seg;
    logic [15:0]           r_count;
    logic                  r_adv;

    logic                  exec_ok;
    logic                  fire;
    logic                  fire_tick;
    sstd_pkg::t_front      front;
    sstd_pkg::t_low        low;
    sstd_pkg::t_cnt_ctrl   cnt_ctrl;
    sstd_pkg::t_cnt_stat   cnt_stat;
    logic [7:0]            tick_seg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= sstd_pkg::PRESCALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_prescale <= i_cfg_data;
        end
    end

    // Only a tick needs the result register.
    assign exec_ok    = !r_in_vld || (r_op != sstd_pkg::OP_TICK) ||
                        !r_out_vld || !i_out_stall;
    assign o_in_stall = !exec_ok;
    assign fire       = r_in_vld && exec_ok;
    assign fire_tick  = fire && (r_op == sstd_pkg::OP_TICK);

    assign front = sstd_pkg::split_front(i_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op     <= sstd_pkg::t_op'(i_operation);
            r_dot_in <= i_dot_on;
            r_front  <= front;
        end
    end

    assign low = sstd_pkg::split_low(r_front.rem);

    always_comb begin
        n_glyph = r_glyph;
        n_dot   = r_dot;
        n_scan  = r_scan;
        if (fire) begin
            case (r_op)
                sstd_pkg::OP_TICK: begin
                    n_scan = r_scan + 2'd1;
                end
                sstd_pkg::OP_SHOW_NUMBER: begin
                    n_glyph[0] = sstd_pkg::glyph(low.ones);
                    n_glyph[1] = sstd_pkg::glyph(low.tens);
                    n_glyph[2] = sstd_pkg::glyph(low.hundreds);
                    n_glyph[3] = r_front.big ? sstd_pkg::glyph(r_front.thousands)
                                             : sstd_pkg::GLYPH_BLANK;
                end
                sstd_pkg::OP_SHOW_DASHES: begin
                    for (int i = 0; i < 4; i++) begin
                        n_glyph[i] = sstd_pkg::GLYPH_DASH;
                    end
                    n_dot = 1'b0;
                end
                sstd_pkg::OP_SET_DOT: begin
                    n_dot = r_dot_in;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph[0] <= sstd_pkg::GLYPH_ZERO;
            r_glyph[1] <= sstd_pkg::GLYPH_ZERO;
            r_glyph[2] <= sstd_pkg::GLYPH_ZERO;
            r_glyph[3] <= sstd_pkg::GLYPH_BLANK;
            r_dot      <= 1'b1;
            r_scan     <= '0;
        end else begin
            r_glyph <= n_glyph;
            r_dot   <= n_dot;
            r_scan  <= n_scan;
        end
    end

    assign cnt_ctrl.tick  = fire_tick;
    assign cnt_ctrl.clear = fire && (r_op == sstd_pkg::OP_CLEAR_COUNT);

    sstd_prescaler u_prescaler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (cnt_ctrl),
        .i_prescale (r_prescale),
        .o_stat     (cnt_stat)
    );

    assign tick_seg = {(r_scan == sstd_pkg::POINT_ROW) && r_dot, r_glyph[r_scan]};

    always_comb begin
        n_out_vld = r_out_vld && i_out_stall;
        if (fire_tick) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_tick) begin
            r_digit <= r_scan;
            r_seg   <= tick_seg;
            r_count <= cnt_stat.count;
            r_adv   <= cnt_stat.advanced;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_digit_index    = r_digit;
    assign o_segments       = r_seg;
    assign o_elapsed_count  = r_count;
    assign o_count_advanced = r_adv;

`ifndef ASSERT_OFF
    // A new result only appears behind a tick that was executed.
    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(fire_tick))
        else $error("result appeared without a tick");

    // A tick must not leave the input register while a result is held.
    a_tick_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && (r_op == sstd_pkg::OP_TICK) && r_out_vld && i_out_stall)
        |-> o_in_stall)
        else $error("tick executed over a stalled result");

    // Each executed tick moves the scan to the next digit.
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_tick |=> (r_scan == 2'($past(r_scan) + 2'd1)))
        else $error("scan row did not advance on a tick");

    // The point is only ever lit on its own digit.
    a_point_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_segments[7]) |-> (o_digit_index == sstd_pkg::POINT_ROW))
        else $error("decimal point on the wrong digit");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_timer_display testbench
// Drives display, dot, dash, clear and scan tick requests into the block and
// checks every scan result against a behavioral model of the glyph store,
// the point flag, the scan position and the prescaled elapsed count. The
// sender and the receiver both idle at random. The run covers several
// prescale settings, a long output hold-off and a prescale of zero, where
// the count moves once every 256 ticks.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          MAX_REPORTED   = 10;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          SWEEP_ITEMS    = 250;
    localparam logic [2:0]  OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0]  OP_RESERVED_LAST  = 3'd7;

    // Glyphs for the digits 9 down to 0, seven bits each.
    localparam logic [69:0] DIGIT_FONT = {7'h6F, 7'h7F, 7'h27, 7'h7D, 7'h6D,
                                          7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    typedef struct packed {
        logic [1:0]  digit;
        logic [7:0]  segments;
        logic [15:0] count;
        logic        advanced;
    } t_scan;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_operation = '0;
    logic [15:0] i_value     = '0;
    logic        i_dot_on    = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_digit_index;
    logic [7:0]  o_segments;
    logic [15:0] o_elapsed_count;
    logic        o_count_advanced;

    // Model of the display state.
    logic [6:0]  shown_glyphs [4];
    logic        point_lit;
    logic [1:0]  scan_digit;
    logic [7:0]  prescale_countdown;
    logic [7:0]  prescale_setting;
    logic [15:0] elapsed_total;

    t_scan       expected_scans [$];

    int failures      = 0;
    int requests_sent = 0;
    int scans_checked = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int pattern_left  = 0;
    int stall_pct     = 0;

    seven_segment_timer_display uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .i_dot_on         (i_dot_on),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digit_index    (o_digit_index),
        .o_segments       (o_segments),
        .o_elapsed_count  (o_elapsed_count),
        .o_count_advanced (o_count_advanced)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [6:0] font_of(input int d);
        return DIGIT_FONT[d*7 +: 7];
    endfunction

    task automatic reset_display_model();
        shown_glyphs[0]    = font_of(0);
        shown_glyphs[1]    = font_of(0);
        shown_glyphs[2]    = font_of(0);
        shown_glyphs[3]    = sstd_pkg::GLYPH_BLANK;
        point_lit          = 1'b1;
        scan_digit         = '0;
        prescale_countdown = sstd_pkg::PRESCALE_RESET;
        prescale_setting   = sstd_pkg::PRESCALE_RESET;
        elapsed_total      = '0;
    endtask

    task automatic predict_display(input logic [2:0] op, input logic [15:0] value,
                                   input logic dot_on);
        int    n;
        t_scan scan;
        begin
            case (op)
                sstd_pkg::OP_TICK: begin
                    scan.advanced      = 1'b0;
                    prescale_countdown = prescale_countdown - 8'd1;
                    if (prescale_countdown == 8'd0) begin
                        prescale_countdown = prescale_setting;
                        elapsed_total      = elapsed_total + 16'd1;
                        scan.advanced      = 1'b1;
                    end
                    scan.digit    = scan_digit;
                    scan.segments = {1'b0, shown_glyphs[scan_digit]};
                    if (scan_digit == sstd_pkg::POINT_ROW && point_lit) begin
                        scan.segments[7] = 1'b1;
                    end
                    scan.count = elapsed_total;
                    expected_scans.push_back(scan);
                    scan_digit = scan_digit + 2'd1;
                end
                sstd_pkg::OP_SHOW_NUMBER: begin
                    n = int'(value) % 10000;
                    shown_glyphs[3] = (value < 16'd1000) ? sstd_pkg::GLYPH_BLANK
                                                         : font_of(n / 1000);
                    shown_glyphs[2] = font_of((n % 1000) / 100);
                    shown_glyphs[1] = font_of((n % 100) / 10);
                    shown_glyphs[0] = font_of(n % 10);
                end
                sstd_pkg::OP_SHOW_DASHES: begin
                    for (int i = 0; i < 4; i++) begin
                        shown_glyphs[i] = sstd_pkg::GLYPH_DASH;
                    end
                    point_lit = 1'b0;
                end
                sstd_pkg::OP_SET_DOT: begin
                    point_lit = dot_on;
                end
                sstd_pkg::OP_CLEAR_COUNT: begin
                    elapsed_total      = '0;
                    prescale_countdown = prescale_setting;
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTED) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // One request per call; the sender works in bursts with random gaps.
    task automatic send_request(input logic [2:0] op, input logic [15:0] value,
                                input logic dot_on);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= value;
        i_dot_on    <= dot_on;
        do @(posedge i_clk); while (o_in_stall);
        predict_display(op, value, dot_on);
        requests_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_scans.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_prescale(input logic [7:0] setting);
        drain_results();
        // Non-tick requests leave no result, so let the pipeline settle too.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= setting;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid      <= 1'b0;
        prescale_setting  = setting;
    endtask

    function automatic logic [2:0] pick_operation();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55) return sstd_pkg::OP_TICK;
            if (r < 70) return sstd_pkg::OP_SHOW_NUMBER;
            if (r < 74) return sstd_pkg::OP_SHOW_DASHES;
            if (r < 84) return sstd_pkg::OP_SET_DOT;
            if (r < 89) return sstd_pkg::OP_CLEAR_COUNT;
            return 3'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST));
        end
    endfunction

    // Bias values toward the blank-digit and ten-thousands boundaries and the top of the range.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 999));
            1:       return 16'($urandom_range(990, 1010));
            2:       return 16'($urandom_range(9990, 10010));
            3:       return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++) begin
            send_request(sstd_pkg::OP_TICK, 16'($urandom), 1'($urandom));
        end
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_request(pick_operation(), pick_value(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic reset_block();
        reset_display_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_directed_glyphs();
        send_ticks(4);
        send_request(sstd_pkg::OP_SHOW_NUMBER, 16'hFFFF, 1'b0);
        send_ticks(4);
        send_request(sstd_pkg::OP_SET_DOT, 16'h0000, 1'b0);
        send_request(sstd_pkg::OP_SHOW_NUMBER, 16'd999, 1'b1);
        send_ticks(4);
        send_request(sstd_pkg::OP_SHOW_NUMBER, 16'd10000, 1'b0);
        send_request(sstd_pkg::OP_SET_DOT, 16'h0000, 1'b1);
        send_request(OP_RESERVED_FIRST, 16'd1234, 1'b0);
        send_request(sstd_pkg::OP_CLEAR_COUNT, 16'h0000, 1'b0);
        send_ticks(4);
        send_request(sstd_pkg::OP_SHOW_DASHES, 16'h0000, 1'b1);
        send_ticks(3);
    endtask

    // A prescale of zero reloads zero, so the count moves every 256 ticks.
    task automatic test_prescale_zero();
        write_prescale(8'd0);
        send_request(sstd_pkg::OP_CLEAR_COUNT, 16'h0000, 1'b0);
        send_ticks(520);
    endtask

    task automatic test_output_holdoff();
        write_prescale(8'd2);
        hold_request = 150;
        send_ticks(40);
        drain_results();
        send_random(30);
    endtask

    task automatic test_random_sweep();
        logic [7:0] settings [5];
        begin
            settings[0] = 8'd255;
            settings[1] = 8'd1;
            settings[2] = 8'($urandom_range(2, 254));
            settings[3] = 8'd3;
            settings[4] = sstd_pkg::PRESCALE_RESET;
            for (int s = 0; s < 5; s++) begin
                write_prescale(settings[s]);
                send_random(SWEEP_ITEMS);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 96);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 20;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_scan got;
        t_scan want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_digit_index, o_segments, o_elapsed_count, o_count_advanced};
            if (expected_scans.size() == 0) begin
                log_failure($sformatf("scan result with none expected: %p", got));
            end else begin
                want = expected_scans.pop_front();
                scans_checked++;
                if (got.digit !== want.digit)
                    log_failure($sformatf("digit index: expected %0d, got %0d",
                                          want.digit, got.digit));
                if (got.segments !== want.segments)
                    log_failure($sformatf("segments: expected %02h, got %02h",
                                          want.segments, got.segments));
                if (got.count !== want.count)
                    log_failure($sformatf("elapsed count: expected %0d, got %0d",
                                          want.count, got.count));
                if (got.advanced !== want.advanced)
                    log_failure($sformatf("count advanced: expected %0b, got %0b",
                                          want.advanced, got.advanced));
            end
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        reset_block();
        test_directed_glyphs();
        test_prescale_zero();
        test_output_holdoff();
        test_random_sweep();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (expected_scans.size() != 0) begin
            log_failure($sformatf("%0d scan results never arrived", expected_scans.size()));
        end
        $display("Sent %0d requests and checked %0d scan results; prescale 0, 1, 255 and",
                 requests_sent, scans_checked);
        $display("others, a long output hold-off and the 256-tick cycle of prescale 0.");
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
